// ===== hw/rtl/array_list_insert_delete_search_top_assert.svh =====
// Assertion macros used by the array list top level.
`ifndef ARRAY_LIST_INSERT_DELETE_SEARCH_TOP_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_SEARCH_TOP_ASSERT_SVH

`ifndef SYNTH
`define ALIST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alist assertion failed");
`define ALIST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alist assertion failed");
`else
`define ALIST_ASSERT_NOW(lbl, ante, cons)
`define ALIST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/alist_pkg.sv =====
// Constants, codes and types of the array list block.
package alist_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int MODE_W   = 2;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int FOUND_W  = 5;
  localparam int COUNT_W  = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_INS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SRCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADPOS   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_LAST,
    ST_INS_PUT,
    ST_DEL,
    ST_DEL_LAST,
    ST_SRCH,
    ST_SRCH_LAST,
    ST_FIN
  } state_t;

endpackage

// ===== hw/rtl/alist_ram.sv =====
// Generic simple dual-port RAM with registered read.
module alist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/array_list_insert_delete_search_top.sv =====
// Array list top level: ordered list of signed words with insert, delete and search.
//
// Input channel in_*: one beat is one request. in_tuser carries the operation
// (0 insert, 1 delete, 2 search), in_tdata the position and the value.
// Result channel out_*: exactly one beat per request, in request order.
// out_tuser carries the status (0 ok, 1 full, 2 bad position, 3 not found),
// out_tdata the found position and the entry count after the operation.
//
// The list lives in one RAM with a registered read; a sequencer
// moves one entry per cycle through a read/write-back pipeline.
// Work per request: an insert shifts the entries from the position to the end
// up by one and then writes the value; an append writes it at once.
// A delete shifts the entries behind the position down by one; a delete of
// the last entry needs no shift. A search reads from position 0 up to the first
// match or the end of the list. Refused and unused requests go straight to the result.
// One request is in work at a time; the next is accepted as soon as the
// sequencer has handed its result to the output register.
// Reset clears the count and the handshake state; RAM contents need no reset.
// A stalled receiver holds the result in the output register; a further
// finished result waits in the sequencer until that register frees up.
module array_list_insert_delete_search_top
  import alist_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // position[5:0], value[37:6], zero pad
  input  logic [MODE_W-1:0]     in_tuser,   // mode[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // found_position[4:0], entry_count[10:5], zero pad
  output logic [STAT_W-1:0]     out_tuser   // status[1:0]
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [ADDR_W-1:0]   rd_r, rd_nxt;
  logic [ADDR_W-1:0]   prev_r, prev_nxt;
  logic                wpend_r, wpend_nxt;
  logic                cpend_r, cpend_nxt;
  logic [STAT_W-1:0]   status_r, status_nxt;
  logic [FOUND_W-1:0]  found_r, found_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [FOUND_W-1:0]  out_found_r, out_found_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [VAL_W-1:0]    ram_wdata;
  logic [VAL_W-1:0]    ram_rdata;

  logic [POS_W-1:0]    in_pos;
  logic [VAL_W-1:0]    in_val;
  logic [CMP_W-1:0]    pos_cmp, cnt_cmp;
  logic [ADDR_W-1:0]   last_addr;
  logic                hit;
  logic                accept;
  logic                out_free;

  assign in_pos    = in_tdata[POS_W-1:0];
  assign in_val    = in_tdata[POS_W +: VAL_W];
  assign pos_cmp   = CMP_W'(in_pos);
  assign cnt_cmp   = CMP_W'(cnt_r);
  assign last_addr = ADDR_W'(cnt_r - CNT_W'(1));
  assign hit       = cpend_r && (ram_rdata == val_r);
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  alist_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (state_r == ST_INS_PUT) begin
      ram_we    = 1'b1;
      ram_waddr = pos_r;
      ram_wdata = val_r;
    end else begin
      ram_we    = wpend_r;
      ram_waddr = (mode_r == MODE_INS) ? prev_r + ADDR_W'(1) : prev_r - ADDR_W'(1);
      ram_wdata = ram_rdata;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    mode_nxt       = mode_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    rd_nxt         = rd_r;
    prev_nxt       = rd_r;
    wpend_nxt      = 1'b0;
    cpend_nxt      = 1'b0;
    status_nxt     = status_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt   = in_tuser;
          pos_nxt    = ADDR_W'(in_pos);
          val_nxt    = in_val;
          status_nxt = STAT_OK;
          found_nxt  = '0;
          state_nxt  = ST_FIN;
          case (in_tuser)
            MODE_INS: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                status_nxt = STAT_FULL;
              end else if (pos_cmp > cnt_cmp) begin
                status_nxt = STAT_BADPOS;
              end else if (pos_cmp == cnt_cmp) begin
                state_nxt = ST_INS_PUT;
              end else begin
                rd_nxt    = last_addr;
                state_nxt = ST_INS;
              end
            end
            MODE_DEL: begin
              if (pos_cmp >= cnt_cmp) begin
                status_nxt = STAT_BADPOS;
              end else if (pos_cmp != cnt_cmp - CMP_W'(1)) begin
                rd_nxt    = ADDR_W'(in_pos) + ADDR_W'(1);
                state_nxt = ST_DEL;
              end
            end
            MODE_SRCH: begin
              status_nxt = STAT_NOTFOUND;
              if (cnt_r != '0) begin
                rd_nxt    = '0;
                state_nxt = ST_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_INS: begin
        wpend_nxt = 1'b1;
        if (rd_r == pos_r) begin
          state_nxt = ST_INS_LAST;
        end else begin
          rd_nxt = rd_r - ADDR_W'(1);
        end
      end
      ST_INS_LAST: begin
        state_nxt = ST_INS_PUT;
      end
      ST_INS_PUT: begin
        state_nxt = ST_FIN;
      end
      ST_DEL: begin
        wpend_nxt = 1'b1;
        if (rd_r == last_addr) begin
          state_nxt = ST_DEL_LAST;
        end else begin
          rd_nxt = rd_r + ADDR_W'(1);
        end
      end
      ST_DEL_LAST: begin
        state_nxt = ST_FIN;
      end
      ST_SRCH: begin
        if (hit) begin
          status_nxt = STAT_OK;
          found_nxt  = FOUND_W'(prev_r);
          state_nxt  = ST_FIN;
        end else begin
          cpend_nxt = 1'b1;
          if (rd_r == last_addr) begin
            state_nxt = ST_SRCH_LAST;
          end else begin
            rd_nxt = rd_r + ADDR_W'(1);
          end
        end
      end
      ST_SRCH_LAST: begin
        if (hit) begin
          status_nxt = STAT_OK;
          found_nxt  = FOUND_W'(prev_r);
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          if (status_r == STAT_OK && mode_r == MODE_INS) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else if (status_r == STAT_OK && mode_r == MODE_DEL) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt  = found_r;
          out_count_nxt  = COUNT_W'(cnt_nxt);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      wpend_r     <= 1'b0;
      cpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wpend_r     <= wpend_nxt;
      cpend_r     <= cpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    rd_r         <= rd_nxt;
    prev_r       <= prev_nxt;
    status_r     <= status_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DATA_W - FOUND_W - COUNT_W){1'b0}}, out_count_r, out_found_r};

`include "array_list_insert_delete_search_top_assert.svh"

  `ALIST_ASSERT_NEXT(a_cnt_only_in_fin, state_r != ST_FIN, cnt_r == $past(cnt_r))
  `ALIST_ASSERT_NOW(a_no_write_idle, state_r == ST_IDLE, !ram_we)
  `ALIST_ASSERT_NOW(a_cnt_in_range, 1'b1, cnt_r <= CNT_W'(CAPACITY))
  `ALIST_ASSERT_NOW(a_found_below_cnt,
                    state_r == ST_FIN && mode_r == MODE_SRCH && status_r == STAT_OK,
                    CMP_W'(found_r) < cnt_cmp)

endmodule
